FILE: rtl/lps_pkg.sv
package lps_pkg;

   localparam int MaxTerms      = 64;
   localparam int FracBits      = 32;
   localparam int XFracBits     = 30;
   localparam int RecipFracBits = 32;

   localparam int XArgW     = 32;
   localparam int CountW    = 7;
   localparam int DegreeW   = 6;
   localparam int ValW      = 44;
   localparam int StepW     = $clog2(MaxTerms + 1);
   localparam int RecipIdxW = $clog2(MaxTerms);

   localparam int MulAW   = 32;
   localparam int MulBW   = 56;
   localparam int MulAccW = MulAW + MulBW + 1;

   localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
   localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
   localparam logic signed [ValW-1:0] ValOne =
      {{(ValW-FracBits-1){1'b0}}, 1'b1, {FracBits{1'b0}}};

   typedef enum logic [1:0] {
      MUL_EXACT,
      MUL_Q30,
      MUL_Q32
   } mul_mode_type;

   typedef enum logic [1:0] {
      MP_IDLE,
      MP_LOW,
      MP_HIGH,
      MP_FINAL
   } mul_phase_type;

   typedef struct packed {
      logic                    start;
      logic [MulAW-1:0]        a_mag;
      logic                    a_neg;
      logic signed [MulBW-1:0] b;
      mul_mode_type            mode;
   } mul_req_type;

   typedef struct packed {
      logic                    idle;
      logic                    done;
      logic signed [MulBW-1:0] value;
   } mul_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMIT0,
      ST_EMIT1,
      ST_XP,
      ST_T1,
      ST_T2,
      ST_NUM,
      ST_PN,
      ST_XS,
      ST_T3,
      ST_EMITK
   } seq_state_type;

endpackage

FILE: rtl/lps_req_if.sv
interface lps_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [lps_pkg::XArgW-1:0] x_arg;
   logic [lps_pkg::CountW-1:0]       term_count;

   modport source (output valid, x_arg, term_count, input ready);
   modport sink (input valid, x_arg, term_count, output ready);
endinterface

FILE: rtl/lps_rsp_if.sv
interface lps_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lps_pkg::DegreeW-1:0]     degree;
   logic signed [lps_pkg::ValW-1:0] poly_value;
   logic signed [lps_pkg::ValW-1:0] poly_slope;
   logic                            last;

   modport source (output valid, degree, poly_value, poly_slope, last, input ready);
   modport sink (input valid, degree, poly_value, poly_slope, last, output ready);
endinterface

FILE: rtl/lps_mul.sv
module lps_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  lps_pkg::mul_req_type mul_req,
   output lps_pkg::mul_rsp_type mul_rsp
);

   lps_pkg::mul_phase_type phase_ff, phase_in;

   logic [lps_pkg::MulAW-1:0]   a_ff;
   logic [lps_pkg::MulBW-1:0]   bmag_ff;
   logic                        neg_ff;
   lps_pkg::mul_mode_type       mode_ff;
   logic [lps_pkg::MulAccW-1:0] acc_ff;

   logic [lps_pkg::MulBW-1:0]     b_mag;
   logic [lps_pkg::MulAW-1:0]     b_part;
   logic [2*lps_pkg::MulAW-1:0]   product;
   logic [lps_pkg::MulAccW-1:0]   mag;
   logic                          big;
   logic signed [lps_pkg::MulBW-1:0] value;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         lps_pkg::MP_IDLE:  if (mul_req.start) phase_in = lps_pkg::MP_LOW;
         lps_pkg::MP_LOW:   phase_in = lps_pkg::MP_HIGH;
         lps_pkg::MP_HIGH:  phase_in = lps_pkg::MP_FINAL;
         lps_pkg::MP_FINAL: phase_in = lps_pkg::MP_IDLE;
         default:           phase_in = lps_pkg::MP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lps_pkg::MP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // operand magnitude and the single 32x32 product
   always_comb begin
      b_mag = mul_req.b[lps_pkg::MulBW-1] ? lps_pkg::MulBW'(-mul_req.b) : mul_req.b;
      if (phase_ff == lps_pkg::MP_LOW) begin
         b_part = bmag_ff[lps_pkg::MulAW-1:0];
      end else begin
         b_part = lps_pkg::MulAW'(bmag_ff[lps_pkg::MulBW-1:lps_pkg::MulAW]);
      end
      product = a_ff * b_part;
   end

   always_ff @(posedge clock) begin
      if (phase_ff == lps_pkg::MP_IDLE && mul_req.start) begin
         a_ff    <= mul_req.a_mag;
         bmag_ff <= b_mag;
         neg_ff  <= mul_req.a_neg ^ mul_req.b[lps_pkg::MulBW-1];
         mode_ff <= mul_req.mode;
      end
      if (phase_ff == lps_pkg::MP_LOW) begin
         acc_ff <= lps_pkg::MulAccW'(product);
      end else if (phase_ff == lps_pkg::MP_HIGH) begin
         acc_ff <= acc_ff + lps_pkg::MulAccW'({product, {lps_pkg::MulAW{1'b0}}});
      end
   end

   // in Q30/Q32 modes round half away from zero on the magnitude and saturate; then sign
   always_comb begin
      case (mode_ff)
         lps_pkg::MUL_Q30:
            mag = (acc_ff + (lps_pkg::MulAccW'(1) << (lps_pkg::XFracBits - 1)))
                  >> lps_pkg::XFracBits;
         lps_pkg::MUL_Q32:
            mag = (acc_ff + (lps_pkg::MulAccW'(1) << (lps_pkg::RecipFracBits - 1)))
                  >> lps_pkg::RecipFracBits;
         default:
            mag = acc_ff;
      endcase
      big = mag > lps_pkg::MulAccW'(lps_pkg::ValMax);
      if (mode_ff != lps_pkg::MUL_EXACT && big) begin
         value = neg_ff ? lps_pkg::MulBW'(lps_pkg::ValMin) : lps_pkg::MulBW'(lps_pkg::ValMax);
      end else if (neg_ff) begin
         value = -$signed(mag[lps_pkg::MulBW-1:0]);
      end else begin
         value = $signed(mag[lps_pkg::MulBW-1:0]);
      end
   end

   always_comb begin
      mul_rsp.idle  = (phase_ff == lps_pkg::MP_IDLE);
      mul_rsp.done  = (phase_ff == lps_pkg::MP_FINAL);
      mul_rsp.value = value;
   end

endmodule

FILE: rtl/legendre_polynomial_series_core.sv
// The degree-0 result is registered from the EMIT0 state that follows the input
// transfer, once the output register is free. Degrees 0 and 1 are emitted from
// their own states; every higher degree runs six products on the shared 32x32
// multiplier, plus one subtract and one update step. A zero count gives no
// result. Emission waits while the output register holds an untaken result.
// Ready only while idle. Reset (synchronous) empties the result register and
// returns the sequencer and multiplier to idle.
module legendre_polynomial_series_core (
   input logic       clock,
   input logic       reset,
   lps_req_if.sink   req_ch,
   lps_rsp_if.source rsp_ch
);

   lps_pkg::seq_state_type state_ff, state_in;

   logic signed [lps_pkg::XArgW-1:0] x_ff;
   logic [lps_pkg::MulAW-1:0]        x_mag_ff;
   logic                             x_neg_ff;
   logic [lps_pkg::StepW-1:0]        count_ff, count_in;
   logic [lps_pkg::StepW-1:0]        step_ff;

   logic signed [lps_pkg::ValW-1:0]  pp_ff, pc_ff, sc_ff, xp_ff, pn_ff, xs_ff;
   logic signed [lps_pkg::MulBW-1:0] num_ff, t2_ff, t3_ff;

   logic                             rsp_valid_ff;
   logic [lps_pkg::DegreeW-1:0]      degree_ff;
   logic signed [lps_pkg::ValW-1:0]  value_ff, slope_ff;
   logic                             last_ff;

   lps_pkg::mul_req_type mul_req;
   lps_pkg::mul_rsp_type mul_rsp;

   logic                             accept;
   logic                             out_free;
   logic                             emit;
   logic [lps_pkg::DegreeW-1:0]      emit_degree;
   logic signed [lps_pkg::ValW-1:0]  emit_value, emit_slope;
   logic                             emit_last;
   logic signed [lps_pkg::ValW-1:0]  x_scaled;
   logic signed [lps_pkg::MulBW:0]   slope_sum;
   logic signed [lps_pkg::ValW-1:0]  slope_next;
   logic [lps_pkg::MulAW-1:0]        x_abs;

   logic [lps_pkg::MulAW-1:0] recip_table [lps_pkg::MaxTerms];

   // reciprocal table round(2^32 / k)
   for (genvar k = 0; k < lps_pkg::MaxTerms; k++) begin : g_recip
      if (k < 2) begin : g_unused
         assign recip_table[k] = '0;
      end else begin : g_entry
         localparam longint unsigned RecipNum = (64'd1 << lps_pkg::RecipFracBits) + k / 2;
         localparam longint unsigned RecipVal = RecipNum / k;
         assign recip_table[k] = lps_pkg::MulAW'(RecipVal);
      end
   end

   lps_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (int'(req_ch.term_count) > lps_pkg::MaxTerms) begin
         count_in = lps_pkg::StepW'(lps_pkg::MaxTerms);
      end else begin
         count_in = lps_pkg::StepW'(req_ch.term_count);
      end
      x_abs = req_ch.x_arg[lps_pkg::XArgW-1] ? lps_pkg::MulAW'(-req_ch.x_arg)
                                             : lps_pkg::MulAW'(req_ch.x_arg);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lps_pkg::ST_IDLE:
            if (accept && count_in != '0) state_in = lps_pkg::ST_EMIT0;
         lps_pkg::ST_EMIT0:
            if (out_free) begin
               state_in = (count_ff == lps_pkg::StepW'(1)) ? lps_pkg::ST_IDLE
                                                           : lps_pkg::ST_EMIT1;
            end
         lps_pkg::ST_EMIT1:
            if (out_free) begin
               state_in = (count_ff == lps_pkg::StepW'(2)) ? lps_pkg::ST_IDLE
                                                           : lps_pkg::ST_XP;
            end
         lps_pkg::ST_XP:  if (mul_rsp.done) state_in = lps_pkg::ST_T1;
         lps_pkg::ST_T1:  if (mul_rsp.done) state_in = lps_pkg::ST_T2;
         lps_pkg::ST_T2:  if (mul_rsp.done) state_in = lps_pkg::ST_NUM;
         lps_pkg::ST_NUM: state_in = lps_pkg::ST_PN;
         lps_pkg::ST_PN:  if (mul_rsp.done) state_in = lps_pkg::ST_XS;
         lps_pkg::ST_XS:  if (mul_rsp.done) state_in = lps_pkg::ST_T3;
         lps_pkg::ST_T3:  if (mul_rsp.done) state_in = lps_pkg::ST_EMITK;
         lps_pkg::ST_EMITK:
            if (out_free) begin
               state_in = (step_ff + lps_pkg::StepW'(2) == count_ff) ? lps_pkg::ST_IDLE
                                                                    : lps_pkg::ST_XP;
            end
         default: state_in = lps_pkg::ST_IDLE;
      endcase
   end

   // outputs: multiplier request and result selection
   always_comb begin
      x_scaled = lps_pkg::ValW'(x_ff) <<< (lps_pkg::FracBits - lps_pkg::XFracBits);
      slope_sum = (lps_pkg::MulBW+1)'(t3_ff) + (lps_pkg::MulBW+1)'(xs_ff);
      if (slope_sum > (lps_pkg::MulBW+1)'(lps_pkg::ValMax)) begin
         slope_next = lps_pkg::ValMax;
      end else if (slope_sum < (lps_pkg::MulBW+1)'(lps_pkg::ValMin)) begin
         slope_next = lps_pkg::ValMin;
      end else begin
         slope_next = lps_pkg::ValW'(slope_sum);
      end

      mul_req.start = 1'b0;
      mul_req.a_mag = x_mag_ff;
      mul_req.a_neg = x_neg_ff;
      mul_req.b     = lps_pkg::MulBW'(pc_ff);
      mul_req.mode  = lps_pkg::MUL_EXACT;
      emit          = 1'b0;
      emit_degree   = lps_pkg::DegreeW'(step_ff + 1'b1);
      emit_value    = pn_ff;
      emit_slope    = slope_next;
      emit_last     = (step_ff + lps_pkg::StepW'(2) == count_ff);

      case (state_ff)
         lps_pkg::ST_EMIT0: begin
            emit        = out_free;
            emit_degree = '0;
            emit_value  = lps_pkg::ValOne;
            emit_slope  = '0;
            emit_last   = (count_ff == lps_pkg::StepW'(1));
         end
         lps_pkg::ST_EMIT1: begin
            emit        = out_free;
            emit_degree = lps_pkg::DegreeW'(1);
            emit_value  = x_scaled;
            emit_slope  = lps_pkg::ValOne;
            emit_last   = (count_ff == lps_pkg::StepW'(2));
         end
         lps_pkg::ST_EMITK: emit = out_free;
         lps_pkg::ST_XP: begin
            mul_req.start = mul_rsp.idle;
            mul_req.mode  = lps_pkg::MUL_Q30;
         end
         lps_pkg::ST_T1: begin
            mul_req.start = mul_rsp.idle;
            mul_req.a_mag = lps_pkg::MulAW'({step_ff, 1'b1});
            mul_req.a_neg = 1'b0;
            mul_req.b     = lps_pkg::MulBW'(xp_ff);
         end
         lps_pkg::ST_T2: begin
            mul_req.start = mul_rsp.idle;
            mul_req.a_mag = lps_pkg::MulAW'(step_ff);
            mul_req.a_neg = 1'b0;
            mul_req.b     = lps_pkg::MulBW'(pp_ff);
         end
         lps_pkg::ST_PN: begin
            mul_req.start = mul_rsp.idle;
            mul_req.a_mag = recip_table[lps_pkg::RecipIdxW'(step_ff + 1'b1)];
            mul_req.a_neg = 1'b0;
            mul_req.b     = num_ff;
            mul_req.mode  = lps_pkg::MUL_Q32;
         end
         lps_pkg::ST_XS: begin
            mul_req.start = mul_rsp.idle;
            mul_req.b     = lps_pkg::MulBW'(sc_ff);
            mul_req.mode  = lps_pkg::MUL_Q30;
         end
         lps_pkg::ST_T3: begin
            mul_req.start = mul_rsp.idle;
            mul_req.a_mag = lps_pkg::MulAW'(step_ff + 1'b1);
            mul_req.a_neg = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         step_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            count_ff <= count_in;
         end
         if (state_ff == lps_pkg::ST_EMIT1 && out_free) begin
            step_ff <= lps_pkg::StepW'(1);
         end else if (state_ff == lps_pkg::ST_EMITK && out_free) begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff     <= req_ch.x_arg;
         x_mag_ff <= x_abs;
         x_neg_ff <= req_ch.x_arg[lps_pkg::XArgW-1];
      end
      case (state_ff)
         lps_pkg::ST_EMIT1:
            if (out_free) begin
               pp_ff <= lps_pkg::ValOne;
               pc_ff <= x_scaled;
               sc_ff <= lps_pkg::ValOne;
            end
         lps_pkg::ST_XP:  if (mul_rsp.done) xp_ff <= lps_pkg::ValW'(mul_rsp.value);
         lps_pkg::ST_T1:  if (mul_rsp.done) num_ff <= mul_rsp.value;
         lps_pkg::ST_T2:  if (mul_rsp.done) t2_ff <= mul_rsp.value;
         lps_pkg::ST_NUM: num_ff <= num_ff - t2_ff;
         lps_pkg::ST_PN:  if (mul_rsp.done) pn_ff <= lps_pkg::ValW'(mul_rsp.value);
         lps_pkg::ST_XS:  if (mul_rsp.done) xs_ff <= lps_pkg::ValW'(mul_rsp.value);
         lps_pkg::ST_T3:  if (mul_rsp.done) t3_ff <= mul_rsp.value;
         lps_pkg::ST_EMITK:
            if (out_free) begin
               pp_ff <= pc_ff;
               pc_ff <= pn_ff;
               sc_ff <= slope_next;
            end
         default: ;
      endcase
      if (emit) begin
         degree_ff <= emit_degree;
         value_ff  <= emit_value;
         slope_ff  <= emit_slope;
         last_ff   <= emit_last;
      end
   end

   assign req_ch.ready      = (state_ff == lps_pkg::ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.degree     = degree_ff;
   assign rsp_ch.poly_value = value_ff;
   assign rsp_ch.poly_slope = slope_ff;
   assign rsp_ch.last       = last_ff;

endmodule

FILE: test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [lps_pkg::ValW-1:0] fixval_type;

   typedef struct {
      logic [lps_pkg::DegreeW-1:0] degree;
      fixval_type                  value;
      fixval_type                  slope;
      logic                        last;
   } legendre_term_type;

   typedef struct {
      logic signed [lps_pkg::XArgW-1:0] x;
      logic [lps_pkg::CountW-1:0]       count;
      bit                               typed;
      fixval_type                       p1;
      fixval_type                       d1;
   } directed_row_type;

   localparam int DirectedItems = 24;
   localparam int RandomItems   = 86;
   localparam int TotalItems    = DirectedItems + RandomItems;

   logic clock = 1'b0;
   logic reset;

   lps_req_if req_if ();
   lps_rsp_if rsp_if ();

   legendre_polynomial_series_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // typed rows hold only counts up to two: p1/d1 are P_1 and P_1'
   directed_row_type directed_rows [DirectedItems] = '{
      '{32'sh0000_0000, 7'd0,   1'b1, 44'sh0, 44'sh0},
      '{32'sh0000_0000, 7'd1,   1'b1, 44'sh0, 44'sh0},
      '{32'sh4000_0000, 7'd1,   1'b1, 44'sh0, 44'sh0},
      '{32'sh4000_0000, 7'd2,   1'b1, 44'sh001_0000_0000, 44'sh001_0000_0000},
      '{32'shC000_0000, 7'd2,   1'b1, 44'shFFF_0000_0000, 44'sh001_0000_0000},
      '{32'sh0000_0000, 7'd2,   1'b1, 44'sh000_0000_0000, 44'sh001_0000_0000},
      '{32'sh7FFF_FFFF, 7'd2,   1'b1, 44'sh001_FFFF_FFFC, 44'sh001_0000_0000},
      '{32'sh8000_0000, 7'd2,   1'b1, 44'shFFE_0000_0000, 44'sh001_0000_0000},
      '{32'sh4000_0000, 7'd64,  1'b0, 44'sh0, 44'sh0},
      '{32'shC000_0000, 7'd64,  1'b0, 44'sh0, 44'sh0},
      '{32'sh0000_0000, 7'd64,  1'b0, 44'sh0, 44'sh0},
      '{32'sh2000_0000, 7'd10,  1'b0, 44'sh0, 44'sh0},
      '{32'shE000_0000, 7'd7,   1'b0, 44'sh0, 44'sh0},
      '{32'sh7FFF_FFFF, 7'd64,  1'b0, 44'sh0, 44'sh0},
      '{32'sh8000_0000, 7'd40,  1'b0, 44'sh0, 44'sh0},
      '{32'sh4000_0000, 7'd127, 1'b0, 44'sh0, 44'sh0},
      '{32'shFF43_9EB2, 7'd65,  1'b0, 44'sh0, 44'sh0},
      '{32'sh0000_0001, 7'd3,   1'b0, 44'sh0, 44'sh0},
      '{32'shFFFF_FFFF, 7'd5,   1'b0, 44'sh0, 44'sh0},
      '{32'sh0000_0000, 7'd0,   1'b0, 44'sh0, 44'sh0},
      '{32'sh1555_5555, 7'd100, 1'b0, 44'sh0, 44'sh0},
      '{32'sh5555_5555, 7'd3,   1'b0, 44'sh0, 44'sh0},
      '{32'sh2AAA_AAAA, 7'd4,   1'b0, 44'sh0, 44'sh0},
      '{32'sh3FFF_FFFF, 7'd20,  1'b0, 44'sh0, 44'sh0}
   };

   legendre_term_type pending_terms [$];
   int                error_count = 0;
   int                items_sent = 0;
   int                sender_idle_pct = 0;
   int                rsp_idle_pct = 0;

   // predictor copy of the block state
   logic signed [lps_pkg::XArgW-1:0] seen_arg;
   logic [lps_pkg::CountW-1:0]       seen_count;
   int                               run_length;
   longint                           run_prev, run_value, run_slope;

   always #5 clock = ~clock;

   // round(a*b / 2^sh), half away from zero, saturated to the value width
   function automatic fixval_type round_product(longint a, longint b, int sh);
      logic [127:0]    mag;
      longint unsigned ua, ub;
      bit              neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      mag = {64'd0, ua} * {64'd0, ub};
      mag = (mag + (128'd1 << (sh - 1))) >> sh;
      if (neg)
         return (mag >= 128'h800_0000_0000) ? lps_pkg::ValMin
                                            : -fixval_type'(mag[lps_pkg::ValW-1:0]);
      return (mag > 128'h7FF_FFFF_FFFF) ? lps_pkg::ValMax
                                        : fixval_type'(mag[lps_pkg::ValW-1:0]);
   endfunction

   function automatic fixval_type clamp_val(longint v);
      if (v > longint'(lps_pkg::ValMax)) return lps_pkg::ValMax;
      if (v < longint'(lps_pkg::ValMin)) return lps_pkg::ValMin;
      return fixval_type'(v);
   endfunction

   function automatic void note_term(int k, fixval_type v, fixval_type s, logic fin);
      legendre_term_type t;
      t.degree = k[lps_pkg::DegreeW-1:0];
      t.value  = v;
      t.slope  = s;
      t.last   = fin;
      pending_terms.push_back(t);
   endfunction

   // Bonnet recurrence for values, P_(i+1)' = (i+1) P_i + x P_i' for slopes
   function automatic void predict_series(logic signed [lps_pkg::XArgW-1:0] x,
                                          logic [lps_pkg::CountW-1:0] count, bit record);
      longint xv, pp, pc, sc, xp, num, rcp, pn;
      int     n;
      xv = longint'(x);
      seen_arg = x;
      seen_count = count;
      n = (int'(count) > lps_pkg::MaxTerms) ? lps_pkg::MaxTerms : int'(count);
      run_length = n;
      if (n == 0) return;
      pp = 0;
      pc = longint'(lps_pkg::ValOne);
      sc = 0;
      if (record) note_term(0, fixval_type'(pc), fixval_type'(sc), n == 1);
      if (n > 1) begin
         pp = pc;
         pc = longint'(round_product(xv, longint'(lps_pkg::ValOne), lps_pkg::XFracBits));
         sc = longint'(lps_pkg::ValOne);
         if (record) note_term(1, fixval_type'(pc), fixval_type'(sc), n == 2);
      end
      for (int i = 1; i + 1 < n; i++) begin
         xp  = longint'(round_product(xv, pc, lps_pkg::XFracBits));
         num = longint'(2 * i + 1) * xp - longint'(i) * pp;
         rcp = longint'(((64'd1 << lps_pkg::RecipFracBits) + longint'((i + 1) / 2))
                        / longint'(i + 1));
         pn  = longint'(round_product(num, rcp, lps_pkg::RecipFracBits));
         sc  = longint'(clamp_val(longint'(i + 1) * pc
                                  + longint'(round_product(xv, sc, lps_pkg::XFracBits))));
         pp  = pc;
         pc  = pn;
         if (record) note_term(i + 1, fixval_type'(pc), fixval_type'(sc), i + 2 == n);
      end
      run_prev = pp;
      run_value = pc;
      run_slope = sc;
   endfunction

   task automatic deliver_item(input directed_row_type row);
      case (items_sent * 3 / TotalItems)
         0: begin
            sender_idle_pct = 25;
            rsp_idle_pct = 81;
         end
         1: begin
            sender_idle_pct = 81;
            rsp_idle_pct = 25;
         end
         default: begin
            sender_idle_pct = 0;
            rsp_idle_pct = 0;
         end
      endcase
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.x_arg <= row.x;
      req_if.term_count <= row.count;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_series(row.x, row.count, !row.typed);
      if (row.typed && row.count != 0) begin
         note_term(0, lps_pkg::ValOne, '0, row.count == 1);
         if (row.count == 2) note_term(1, row.p1, row.d1, 1'b1);
      end
      items_sent++;
   endtask

   task automatic hold_until_drained;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_terms.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      legendre_term_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_terms.size() == 0) begin
            $display("%0t: unexpected transfer, degree %0d", $time, rsp_if.degree);
            error_count++;
         end else begin
            want = pending_terms.pop_front();
            if (rsp_if.degree !== want.degree) begin
               $display("%0t: degree expected %0d actual %0d",
                        $time, want.degree, rsp_if.degree);
               error_count++;
            end
            if (rsp_if.poly_value !== want.value) begin
               $display("%0t: poly_value (degree %0d) expected %0d actual %0d",
                        $time, want.degree, want.value, rsp_if.poly_value);
               error_count++;
            end
            if (rsp_if.poly_slope !== want.slope) begin
               $display("%0t: poly_slope (degree %0d) expected %0d actual %0d",
                        $time, want.degree, want.slope, rsp_if.poly_slope);
               error_count++;
            end
            if (rsp_if.last !== want.last) begin
               $display("%0t: last (degree %0d) expected %0d actual %0d",
                        $time, want.degree, want.last, rsp_if.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      directed_row_type row;
      int unsigned      pick;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.x_arg = '0;
      req_if.term_count = '0;
      seen_arg = '0;
      seen_count = '0;
      run_length = 0;
      run_prev = 0;
      run_value = 0;
      run_slope = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) deliver_item(directed_rows[i]);
      hold_until_drained();

      for (int i = 0; i < RandomItems; i++) begin
         row.typed = 1'b0;
         row.p1 = '0;
         row.d1 = '0;
         pick = $urandom_range(99);
         if (pick < 6)
            row.x = $urandom;
         else if (pick < 14)
            row.x = $urandom_range(1) ? 32'sh4000_0000 : 32'shC000_0000;
         else
            row.x = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
         pick = $urandom_range(99);
         if (pick < 60)
            row.count = lps_pkg::CountW'($urandom_range(8, 0));
         else if (pick < 85)
            row.count = lps_pkg::CountW'($urandom_range(24, 9));
         else if (pick < 95)
            row.count = lps_pkg::CountW'($urandom_range(64, 25));
         else
            row.count = lps_pkg::CountW'($urandom_range(127, 65));
         deliver_item(row);
         if (i == RandomItems / 2) hold_until_drained();
      end

      hold_until_drained();
      repeat (30) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
